>>> sv/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared widths, command codes, register indexes and bundles of the
// pan/tilt target tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

    localparam int COORD_BITS    = 10;
    localparam int ANG_BITS      = 24;
    localparam int GAIN_BITS     = 16;
    localparam int MODE_BITS     = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [7:0] SYNC_BYTE = 8'h55;

    typedef enum logic [2:0] {
        OP_START     = 3'd0,
        OP_STOP      = 3'd1,
        OP_CLEAR     = 3'd2,
        OP_TICK      = 3'd3,
        OP_PACKET    = 3'd4,
        OP_COMPUTE   = 3'd5,
        OP_PAN_PLUS  = 3'd6,
        OP_PAN_MINUS = 3'd7
    } t_opcode;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CTR_COL   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CTR_ROW   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_PAN  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_TILT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_X     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_X     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AIM_TOL   = 3'd6;

    localparam logic [COORD_BITS-1:0] CTR_COL_RST  = 10'd160;
    localparam logic [COORD_BITS-1:0] CTR_ROW_RST  = 10'd120;
    localparam logic [GAIN_BITS-1:0]  GAIN_RST     = 16'd410;
    localparam logic [COORD_BITS-1:0] MIN_X_RST    = 10'd0;
    localparam logic [COORD_BITS-1:0] MAX_X_RST    = 10'd319;
    localparam logic [COORD_BITS-1:0] AIM_TOL_RST  = 10'd30;

    localparam logic [MODE_BITS-1:0] MODE_IDLE = 3'd0;

    typedef struct packed {
        logic [COORD_BITS-1:0] ctr_col;
        logic [COORD_BITS-1:0] ctr_row;
        logic [GAIN_BITS-1:0]  gain_pan;
        logic [GAIN_BITS-1:0]  gain_tilt;
        logic [COORD_BITS-1:0] min_x;
        logic [COORD_BITS-1:0] max_x;
        logic [COORD_BITS-1:0] aim_tol;
    } t_cfg;

    typedef struct packed {
        t_opcode               opcode;
        logic [7:0]            header;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  detected;
    } t_cmd;

    typedef struct packed {
        logic [MODE_BITS-1:0]       mode;
        logic [COORD_BITS-1:0]      x;
        logic [COORD_BITS-1:0]      y;
        logic signed [ANG_BITS-1:0] pan;
        logic signed [ANG_BITS-1:0] tilt;
        logic                       detected;
        logic                       aimed;
    } t_snap;

endpackage

`default_nettype wire

>>> sv/ptt_in_if.sv
// ----------------------------------------------------------------------------
// ptt_in_if
// Command channel: opcode plus camera packet fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptt_in_if;
    logic                            valid;
    logic                            ready;
    logic [2:0]                      opcode;
    logic [7:0]                      packet_header;
    logic [ptt_pkg::COORD_BITS-1:0]  x_in;
    logic [ptt_pkg::COORD_BITS-1:0]  y_in;
    logic                            detected_in;

    modport source (
        output valid, opcode, packet_header, x_in, y_in, detected_in,
        input  ready
    );
    modport sink (
        input  valid, opcode, packet_header, x_in, y_in, detected_in,
        output ready
    );
endinterface

`default_nettype wire

>>> sv/ptt_out_if.sv
// ----------------------------------------------------------------------------
// ptt_out_if
// Snapshot channel: tracker mode, target and servo angles.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptt_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [ptt_pkg::MODE_BITS-1:0]         mode_out;
    logic [ptt_pkg::COORD_BITS-1:0]        x_out;
    logic [ptt_pkg::COORD_BITS-1:0]        y_out;
    logic signed [ptt_pkg::ANG_BITS-1:0]   pan_out;
    logic signed [ptt_pkg::ANG_BITS-1:0]   tilt_out;
    logic                                  detected_out;
    logic                                  aimed_out;

    modport source (
        output valid, mode_out, x_out, y_out, pan_out, tilt_out, detected_out, aimed_out,
        input  ready
    );
    modport sink (
        input  valid, mode_out, x_out, y_out, pan_out, tilt_out, detected_out, aimed_out,
        output ready
    );
endinterface

`default_nettype wire

>>> sv/ptt_cfg_regs.sv
// ----------------------------------------------------------------------------
// ptt_cfg_regs
// Write-only configuration register file.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_cfg_regs (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [ptt_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [ptt_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output ptt_pkg::t_cfg                           o_cfg
);

    ptt_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ctr_col   <= ptt_pkg::CTR_COL_RST;
            r_cfg.ctr_row   <= ptt_pkg::CTR_ROW_RST;
            r_cfg.gain_pan  <= ptt_pkg::GAIN_RST;
            r_cfg.gain_tilt <= ptt_pkg::GAIN_RST;
            r_cfg.min_x     <= ptt_pkg::MIN_X_RST;
            r_cfg.max_x     <= ptt_pkg::MAX_X_RST;
            r_cfg.aim_tol   <= ptt_pkg::AIM_TOL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ptt_pkg::CFG_CTR_COL:   r_cfg.ctr_col   <= i_cfg_data[ptt_pkg::COORD_BITS-1:0];
                ptt_pkg::CFG_CTR_ROW:   r_cfg.ctr_row   <= i_cfg_data[ptt_pkg::COORD_BITS-1:0];
                ptt_pkg::CFG_GAIN_PAN:  r_cfg.gain_pan  <= i_cfg_data[ptt_pkg::GAIN_BITS-1:0];
                ptt_pkg::CFG_GAIN_TILT: r_cfg.gain_tilt <= i_cfg_data[ptt_pkg::GAIN_BITS-1:0];
                ptt_pkg::CFG_MIN_X:     r_cfg.min_x     <= i_cfg_data[ptt_pkg::COORD_BITS-1:0];
                ptt_pkg::CFG_MAX_X:     r_cfg.max_x     <= i_cfg_data[ptt_pkg::COORD_BITS-1:0];
                ptt_pkg::CFG_AIM_TOL:   r_cfg.aim_tol   <= i_cfg_data[ptt_pkg::COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> sv/ptt_axis.sv
// ----------------------------------------------------------------------------
// ptt_axis
// One servo axis: deadzoned pixel error times Q4.12 gain, rounded and
// added to the Q16.8 angle with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_axis #(
    parameter int DEADZONE = 5
) (
    input  wire logic signed [ptt_pkg::ANG_BITS-1:0]   i_angle,
    input  wire logic [ptt_pkg::COORD_BITS-1:0]        i_pos,
    input  wire logic [ptt_pkg::COORD_BITS-1:0]        i_center,
    input  wire logic [ptt_pkg::GAIN_BITS-1:0]         i_gain,
    output logic signed [ptt_pkg::ANG_BITS-1:0]        o_angle
);

    localparam int ERR_W  = ptt_pkg::COORD_BITS + 1;
    localparam int PROD_W = ptt_pkg::COORD_BITS + ptt_pkg::GAIN_BITS;
    localparam int RND_W  = PROD_W - 3;
    localparam int SUM_W  = ptt_pkg::ANG_BITS + 2;

    localparam logic signed [SUM_W-1:0] ANG_MAX = SUM_W'((1 << (ptt_pkg::ANG_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] ANG_MIN = -SUM_W'(1 << (ptt_pkg::ANG_BITS - 1));

    logic signed [ERR_W-1:0]   err;
    logic [ptt_pkg::COORD_BITS-1:0] err_mag;
    logic                      in_dz;
    logic [PROD_W-1:0]         prod_mag;
    logic [PROD_W:0]           prod_rnd;
    logic [RND_W-1:0]          inc_mag;
    logic signed [SUM_W-1:0]   inc;
    logic signed [SUM_W-1:0]   sum;

    always_comb begin
        err      = $signed({1'b0, i_pos}) - $signed({1'b0, i_center});
        err_mag  = err[ERR_W-1] ? ptt_pkg::COORD_BITS'(-err) : err[ptt_pkg::COORD_BITS-1:0];
        in_dz    = {1'b0, err_mag} < ERR_W'(DEADZONE);
        prod_mag = in_dz ? '0 : PROD_W'(err_mag) * PROD_W'(i_gain);
        // round half away from zero on the magnitude, then divide by 16
        prod_rnd = {1'b0, prod_mag} + (PROD_W + 1)'(8);
        inc_mag  = prod_rnd[PROD_W:4];
        inc      = err[ERR_W-1] ? -$signed(SUM_W'(inc_mag)) : $signed(SUM_W'(inc_mag));
        sum      = SUM_W'(i_angle) + inc;
        if (sum > ANG_MAX) begin
            o_angle = ANG_MAX[ptt_pkg::ANG_BITS-1:0];
        end else if (sum < ANG_MIN) begin
            o_angle = ANG_MIN[ptt_pkg::ANG_BITS-1:0];
        end else begin
            o_angle = sum[ptt_pkg::ANG_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

>>> sv/ptt_core.sv
// ----------------------------------------------------------------------------
// ptt_core
// Tracker state: mode machine, target position, servo angles and flags.
// Applies one command per step and flags when a snapshot is due.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_core #(
    parameter int DEADZONE  = 5,
    parameter int PAN_STEP  = 10,
    parameter int PAN_HOME  = 23040,
    parameter int TILT_HOME = 23040
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire ptt_pkg::t_cmd i_cmd,
    input  wire ptt_pkg::t_cfg i_cfg,
    output logic               o_emit,
    output ptt_pkg::t_snap     o_snap
);

    localparam int CW  = ptt_pkg::COORD_BITS;
    localparam int AW  = ptt_pkg::ANG_BITS;
    localparam logic [CW:0] STEP = (CW + 1)'(PAN_STEP);

    typedef enum logic [ptt_pkg::MODE_BITS-1:0] {
        M_IDLE   = 3'd0,
        M_SEARCH = 3'd1,
        M_FOLLOW = 3'd2,
        M_LOST   = 3'd3,
        M_AIMED  = 3'd4
    } t_mode;

    t_mode                r_mode, n_mode;
    logic [CW-1:0]        r_tx, n_tx;
    logic [CW-1:0]        r_ty, n_ty;
    logic signed [AW-1:0] r_pan, n_pan;
    logic signed [AW-1:0] r_tilt, n_tilt;
    logic                 r_seen, n_seen;
    logic                 r_aim, n_aim;

    logic signed [AW-1:0] pan_next, tilt_next;
    logic signed [CW:0]   dx, dy;
    logic [CW-1:0]        adx, ady;
    logic                 aim;
    logic [CW:0]          x_plus, x_floor;

    ptt_axis #(.DEADZONE(DEADZONE)) u_pan (
        .i_angle  (r_pan),
        .i_pos    (r_tx),
        .i_center (i_cfg.ctr_col),
        .i_gain   (i_cfg.gain_pan),
        .o_angle  (pan_next)
    );

    ptt_axis #(.DEADZONE(DEADZONE)) u_tilt (
        .i_angle  (r_tilt),
        .i_pos    (r_ty),
        .i_center (i_cfg.ctr_row),
        .i_gain   (i_cfg.gain_tilt),
        .o_angle  (tilt_next)
    );

    always_comb begin
        dx      = $signed({1'b0, i_cmd.x}) - $signed({1'b0, i_cfg.ctr_col});
        dy      = $signed({1'b0, i_cmd.y}) - $signed({1'b0, i_cfg.ctr_row});
        adx     = dx[CW] ? CW'(-dx) : dx[CW-1:0];
        ady     = dy[CW] ? CW'(-dy) : dy[CW-1:0];
        aim     = i_cmd.detected && (adx < i_cfg.aim_tol) && (ady < i_cfg.aim_tol);
        x_plus  = {1'b0, r_tx} + STEP;
        x_floor = {1'b0, i_cfg.min_x} + STEP;

        n_mode = r_mode;
        n_tx   = r_tx;
        n_ty   = r_ty;
        n_pan  = r_pan;
        n_tilt = r_tilt;
        n_seen = r_seen;
        n_aim  = r_aim;

        case (i_cmd.opcode)
            ptt_pkg::OP_START: begin
                if (r_mode == M_IDLE) n_mode = M_SEARCH;
            end
            ptt_pkg::OP_STOP: begin
                if (r_mode == M_SEARCH) n_mode = M_IDLE;
            end
            ptt_pkg::OP_CLEAR: begin
                if (r_mode == M_AIMED) n_mode = M_SEARCH;
            end
            ptt_pkg::OP_PACKET: begin
                if (i_cmd.header == ptt_pkg::SYNC_BYTE) begin
                    n_tx   = i_cmd.x;
                    n_ty   = i_cmd.y;
                    n_seen = i_cmd.detected;
                    n_aim  = aim;
                    // target event is applied in the same step
                    if (i_cmd.detected) begin
                        if (aim) begin
                            if (r_mode == M_FOLLOW) n_mode = M_AIMED;
                        end else if (r_mode == M_SEARCH || r_mode == M_LOST) begin
                            n_mode = M_FOLLOW;
                        end
                    end else if (r_mode == M_FOLLOW) begin
                        n_mode = M_LOST;
                    end
                end
            end
            ptt_pkg::OP_COMPUTE: begin
                if (r_mode != M_IDLE) begin
                    n_pan  = pan_next;
                    n_tilt = tilt_next;
                end
            end
            ptt_pkg::OP_PAN_PLUS: begin
                if (x_plus <= {1'b0, i_cfg.max_x}) n_tx = x_plus[CW-1:0];
            end
            ptt_pkg::OP_PAN_MINUS: begin
                if ({1'b0, r_tx} >= x_floor) n_tx = r_tx - STEP[CW-1:0];
            end
            default: ;
        endcase

        o_emit = i_step && ((n_mode != r_mode) ||
                 (i_cmd.opcode == ptt_pkg::OP_TICK && n_mode != M_IDLE));
        o_snap.mode     = n_mode;
        o_snap.x        = n_tx;
        o_snap.y        = n_ty;
        o_snap.pan      = n_pan;
        o_snap.tilt     = n_tilt;
        o_snap.detected = n_seen;
        o_snap.aimed    = n_aim;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_tx   <= ptt_pkg::CTR_COL_RST;
            r_ty   <= ptt_pkg::CTR_ROW_RST;
            r_pan  <= AW'(PAN_HOME);
            r_tilt <= AW'(TILT_HOME);
            r_seen <= 1'b0;
            r_aim  <= 1'b0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_tx   <= n_tx;
            r_ty   <= n_ty;
            r_pan  <= n_pan;
            r_tilt <= n_tilt;
            r_seen <= n_seen;
            r_aim  <= n_aim;
        end
    end

endmodule

`default_nettype wire

>>> sv/pan_tilt_target_tracker_unit.sv
// ----------------------------------------------------------------------------
// pan_tilt_target_tracker_unit
// Pan/tilt target tracker: mode machine, camera packet handling and servo
// angle update, one command per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one command per request: start, stop, clear, tick,
//   camera packet, compute, pan plus or pan minus. o_res carries a state
//   snapshot whenever the mode changes and on every tick while not idle;
//   other commands give no snapshot.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   no command is in flight.
//   A command is held in the input register and is applied to the tracker
//   state once the output register can take its snapshot; on that edge any
//   snapshot is loaded into the output register, raising o_res.valid.
//   Throughput is one command per cycle while the receiver does not stall;
//   the single-step update (one 16x10 multiply, round and saturate per axis)
//   fits between the input and output registers.
//   If the receiver stalls with a snapshot pending, the command in the
//   input register waits and i_cmd.ready drops once it is full.
//   Reset restores the registers to their defaults, the mode to idle, the
//   target to the centre and the angles to their home values.
// ----------------------------------------------------------------------------
`default_nettype none

module pan_tilt_target_tracker_unit #(
    parameter int DEADZONE  = 5,
    parameter int PAN_STEP  = 10,
    parameter int PAN_HOME  = 23040,
    parameter int TILT_HOME = 23040
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    ptt_in_if.sink                                  i_cmd,
    ptt_out_if.source                               o_res,
    input  wire logic                               i_cfg_we,
    input  wire logic [ptt_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [ptt_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    ptt_pkg::t_cfg  cfg;
    ptt_pkg::t_cmd  r_cmd;
    logic           r_cmd_valid;
    ptt_pkg::t_snap r_out, snap;
    logic           r_out_valid;
    logic           emit;
    logic           advance;

    ptt_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // the held request is applied only when the result slot can take it
    assign advance     = r_cmd_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_cmd_valid || advance;

    ptt_core #(
        .DEADZONE  (DEADZONE),
        .PAN_STEP  (PAN_STEP),
        .PAN_HOME  (PAN_HOME),
        .TILT_HOME (TILT_HOME)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_cmd   (r_cmd),
        .i_cfg   (cfg),
        .o_emit  (emit),
        .o_snap  (snap)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_cmd_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_cmd.opcode   <= ptt_pkg::t_opcode'(i_cmd.opcode);
            r_cmd.header   <= i_cmd.packet_header;
            r_cmd.x        <= i_cmd.x_in;
            r_cmd.y        <= i_cmd.y_in;
            r_cmd.detected <= i_cmd.detected_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= snap;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.mode_out     = r_out.mode;
    assign o_res.x_out        = r_out.x;
    assign o_res.y_out        = r_out.y;
    assign o_res.pan_out      = r_out.pan;
    assign o_res.tilt_out     = r_out.tilt;
    assign o_res.detected_out = r_out.detected;
    assign o_res.aimed_out    = r_out.aimed;

    a_accept_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> r_cmd_valid)
        else $error("accepted request not held in input register");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd_valid && !advance) |=> (r_cmd_valid && $stable(r_cmd)))
        else $error("stalled request lost or changed");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance))
        else $error("snapshot appeared without an applied request");

    a_idle_from_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && emit && snap.mode == ptt_pkg::MODE_IDLE)
            |-> (r_cmd.opcode == ptt_pkg::OP_STOP))
        else $error("snapshot in idle not caused by stop");

endmodule

`default_nettype wire

>>> tb/sv/pan_tilt_target_tracker_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pan_tilt_target_tracker_unit_tb
// Drives command requests into the tracker under random stalls on both
// channels. A cycle-free model of the mode machine, packet handling and
// servo update predicts every snapshot, and each received snapshot is
// compared field by field in order. Register settings change between runs.
// ----------------------------------------------------------------------------
module pan_tilt_target_tracker_unit_tb;

    localparam int DEADZONE    = 5;
    localparam int PAN_STEP    = 10;
    localparam int PAN_HOME    = 23040;
    localparam int TILT_HOME   = 23040;
    localparam int IDLE_PCT    = 31;
    localparam int DRAIN_WAIT  = 4;
    localparam int STALL_LIMIT = 1000;
    localparam int PHASES      = 8;
    localparam int PHASE_REQS  = 155;
    localparam longint ANG_TOP    = 64'sd8388607;
    localparam longint ANG_BOTTOM = -64'sd8388608;
    localparam int CW = ptt_pkg::COORD_BITS;
    localparam int AW = ptt_pkg::ANG_BITS;
    localparam int GW = ptt_pkg::GAIN_BITS;
    localparam int IW = ptt_pkg::CFG_IDX_BITS;
    localparam int DW = ptt_pkg::CFG_DATA_BITS;

    typedef enum logic [2:0] {
        TRK_IDLE   = 3'd0,
        TRK_SEARCH = 3'd1,
        TRK_FOLLOW = 3'd2,
        TRK_LOST   = 3'd3,
        TRK_AIMED  = 3'd4
    } t_track_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [IW-1:0] i_cfg_idx;
    logic [DW-1:0] i_cfg_data;

    ptt_in_if  cmd_if ();
    ptt_out_if snap_if ();

    pan_tilt_target_tracker_unit #(
        .DEADZONE  (DEADZONE),
        .PAN_STEP  (PAN_STEP),
        .PAN_HOME  (PAN_HOME),
        .TILT_HOME (TILT_HOME)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_if),
        .o_res      (snap_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the tracker
    ptt_pkg::t_cfg        cfg;
    t_track_mode          trk_mode;
    logic [CW-1:0]        tgt_x;
    logic [CW-1:0]        tgt_y;
    logic signed [AW-1:0] pan_ang;
    logic signed [AW-1:0] tilt_ang;
    logic                 seen;
    logic                 aimed;

    ptt_pkg::t_cmd  queued_cmds[$];
    ptt_pkg::t_snap predicted_snaps[$];
    ptt_pkg::t_cmd  taken_cmd;
    ptt_pkg::t_snap new_snap;
    ptt_pkg::t_snap got_snap;
    bit    cmd_taken = 1'b0;
    bit    steady = 1'b0;
    int    mismatches = 0;
    int    quiet_cycles = 0;

    function automatic logic signed [AW-1:0] steer(
        input logic signed [AW-1:0] ang,
        input logic [CW-1:0]        pos,
        input logic [CW-1:0]        ctr,
        input logic [GW-1:0]        gain
    );
        int     err;
        longint g;
        longint a;
        longint prod;
        longint mag;
        longint sum;
        err = int'(pos) - int'(ctr);
        if (err > -DEADZONE && err < DEADZONE) err = 0;
        g = gain;
        a = ang;
        prod = longint'(err) * g;
        mag = (prod < 0) ? -prod : prod;
        // round half away from zero on the Q4.12 -> Q.8 shift
        mag = (mag + 8) / 16;
        sum = a + ((prod < 0) ? -mag : mag);
        if (sum > ANG_TOP) sum = ANG_TOP;
        if (sum < ANG_BOTTOM) sum = ANG_BOTTOM;
        return AW'(sum);
    endfunction

    function automatic bit advance_tracker(input ptt_pkg::t_cmd c, output ptt_pkg::t_snap s);
        t_track_mode prior;
        bit          hit;
        int          dx;
        int          dy;
        int          tol;
        prior = trk_mode;
        case (c.opcode)
            ptt_pkg::OP_START: begin
                if (trk_mode == TRK_IDLE) trk_mode = TRK_SEARCH;
            end
            ptt_pkg::OP_STOP: begin
                if (trk_mode == TRK_SEARCH) trk_mode = TRK_IDLE;
            end
            ptt_pkg::OP_CLEAR: begin
                if (trk_mode == TRK_AIMED) trk_mode = TRK_SEARCH;
            end
            ptt_pkg::OP_PACKET: begin
                if (c.header == ptt_pkg::SYNC_BYTE) begin
                    tgt_x = c.x;
                    tgt_y = c.y;
                    dx = int'(c.x) - int'(cfg.ctr_col);
                    dy = int'(c.y) - int'(cfg.ctr_row);
                    tol = int'(cfg.aim_tol);
                    hit = c.detected && ((dx < 0) ? -dx : dx) < tol
                          && ((dy < 0) ? -dy : dy) < tol;
                    if (c.detected) begin
                        if (hit) begin
                            if (trk_mode == TRK_FOLLOW) trk_mode = TRK_AIMED;
                        end else if (trk_mode == TRK_SEARCH || trk_mode == TRK_LOST) begin
                            trk_mode = TRK_FOLLOW;
                        end
                    end else if (trk_mode == TRK_FOLLOW) begin
                        trk_mode = TRK_LOST;
                    end
                    seen = c.detected;
                    aimed = hit;
                end
            end
            ptt_pkg::OP_COMPUTE: begin
                if (trk_mode != TRK_IDLE) begin
                    pan_ang = steer(pan_ang, tgt_x, cfg.ctr_col, cfg.gain_pan);
                    tilt_ang = steer(tilt_ang, tgt_y, cfg.ctr_row, cfg.gain_tilt);
                end
            end
            ptt_pkg::OP_PAN_PLUS: begin
                if (int'(tgt_x) + PAN_STEP <= int'(cfg.max_x))
                    tgt_x = CW'(int'(tgt_x) + PAN_STEP);
            end
            ptt_pkg::OP_PAN_MINUS: begin
                if (int'(tgt_x) >= int'(cfg.min_x) + PAN_STEP)
                    tgt_x = CW'(int'(tgt_x) - PAN_STEP);
            end
            default: ;
        endcase
        s.mode = trk_mode;
        s.x = tgt_x;
        s.y = tgt_y;
        s.pan = pan_ang;
        s.tilt = tilt_ang;
        s.detected = seen;
        s.aimed = aimed;
        return (trk_mode != prior) || (c.opcode == ptt_pkg::OP_TICK && trk_mode != TRK_IDLE);
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic check_snapshot(input ptt_pkg::t_snap got);
        ptt_pkg::t_snap want;
        if (predicted_snaps.size() == 0) begin
            note_mismatch($sformatf("snapshot with none expected, mode %0d", got.mode));
            return;
        end
        want = predicted_snaps.pop_front();
        if (got.mode !== want.mode)
            note_mismatch($sformatf("mode exp %0d got %0d", want.mode, got.mode));
        if (got.x !== want.x)
            note_mismatch($sformatf("x exp %0d got %0d", want.x, got.x));
        if (got.y !== want.y)
            note_mismatch($sformatf("y exp %0d got %0d", want.y, got.y));
        if (got.pan !== want.pan)
            note_mismatch($sformatf("pan exp %0d got %0d", want.pan, got.pan));
        if (got.tilt !== want.tilt)
            note_mismatch($sformatf("tilt exp %0d got %0d", want.tilt, got.tilt));
        if (got.detected !== want.detected)
            note_mismatch($sformatf("detected exp %0b got %0b", want.detected, got.detected));
        if (got.aimed !== want.aimed)
            note_mismatch($sformatf("aimed exp %0b got %0b", want.aimed, got.aimed));
    endtask

    task automatic cfg_write(input logic [IW-1:0] idx,
                             input logic [DW-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            ptt_pkg::CFG_CTR_COL:   cfg.ctr_col   = value[CW-1:0];
            ptt_pkg::CFG_CTR_ROW:   cfg.ctr_row   = value[CW-1:0];
            ptt_pkg::CFG_GAIN_PAN:  cfg.gain_pan  = value;
            ptt_pkg::CFG_GAIN_TILT: cfg.gain_tilt = value;
            ptt_pkg::CFG_MIN_X:     cfg.min_x     = value[CW-1:0];
            ptt_pkg::CFG_MAX_X:     cfg.max_x     = value[CW-1:0];
            ptt_pkg::CFG_AIM_TOL:   cfg.aim_tol   = value[CW-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_phase(input int k);
        ptt_pkg::t_cfg nc;
        case (k)
            0: begin
                nc.ctr_col = 10'd1023;   nc.ctr_row = 10'd0;
                nc.gain_pan = 16'hFFFF;  nc.gain_tilt = 16'hFFFF;
                nc.min_x = 10'd0;        nc.max_x = 10'd1023;
                nc.aim_tol = 10'd1023;
            end
            1: begin
                nc.ctr_col = 10'd0;      nc.ctr_row = 10'd1023;
                nc.gain_pan = 16'd0;     nc.gain_tilt = 16'd0;
                nc.min_x = 10'd1023;     nc.max_x = 10'd0;
                nc.aim_tol = 10'd0;
            end
            2: begin
                nc.ctr_col = ptt_pkg::CTR_COL_RST;  nc.ctr_row = ptt_pkg::CTR_ROW_RST;
                nc.gain_pan = ptt_pkg::GAIN_RST;    nc.gain_tilt = ptt_pkg::GAIN_RST;
                nc.min_x = ptt_pkg::MIN_X_RST;      nc.max_x = ptt_pkg::MAX_X_RST;
                nc.aim_tol = ptt_pkg::AIM_TOL_RST;
            end
            3: begin
                nc.ctr_col = 10'd0;      nc.ctr_row = 10'd1023;
                nc.gain_pan = 16'hFFFF;  nc.gain_tilt = 16'hFFFF;
                nc.min_x = 10'd5;        nc.max_x = 10'd1000;
                nc.aim_tol = 10'd5;
            end
            default: begin
                nc.ctr_col = 10'($urandom);
                nc.ctr_row = 10'($urandom);
                nc.gain_pan = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000));
                nc.gain_tilt = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000));
                nc.min_x = 10'($urandom_range(300));
                nc.max_x = 10'($urandom_range(1023, 300));
                nc.aim_tol = 10'($urandom_range(80));
            end
        endcase
        cfg_write(ptt_pkg::CFG_CTR_COL, DW'(nc.ctr_col));
        cfg_write(ptt_pkg::CFG_CTR_ROW, DW'(nc.ctr_row));
        cfg_write(ptt_pkg::CFG_GAIN_PAN, nc.gain_pan);
        cfg_write(ptt_pkg::CFG_GAIN_TILT, nc.gain_tilt);
        cfg_write(ptt_pkg::CFG_MIN_X, DW'(nc.min_x));
        cfg_write(ptt_pkg::CFG_MAX_X, DW'(nc.max_x));
        cfg_write(ptt_pkg::CFG_AIM_TOL, DW'(nc.aim_tol));
    endtask

    task automatic push_req(input ptt_pkg::t_opcode op, input logic [7:0] hdr,
                            input int x, input int y, input bit det);
        ptt_pkg::t_cmd c;
        c.opcode = op;
        c.header = hdr;
        c.x = CW'(x);
        c.y = CW'(y);
        c.detected = det;
        queued_cmds.push_back(c);
    endtask

    // random coordinate, or one around the centre, on the aim window edge or deadzone edge
    function automatic logic [CW-1:0] pick_coord(input logic [CW-1:0] ctr);
        int off;
        int v;
        case ($urandom_range(3))
            0: return CW'($urandom);
            1: off = int'($urandom_range(80)) - 40;
            2: off = int'(cfg.aim_tol) - int'($urandom_range(1));
            default: off = DEADZONE - int'($urandom_range(1));
        endcase
        if ($urandom_range(1) == 1) off = -off;
        v = int'(ctr) + off;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return CW'(v);
    endfunction

    function automatic ptt_pkg::t_cmd random_req();
        ptt_pkg::t_cmd c;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 8)       c.opcode = ptt_pkg::OP_START;
        else if (pick < 12) c.opcode = ptt_pkg::OP_STOP;
        else if (pick < 20) c.opcode = ptt_pkg::OP_CLEAR;
        else if (pick < 35) c.opcode = ptt_pkg::OP_TICK;
        else if (pick < 68) c.opcode = ptt_pkg::OP_PACKET;
        else if (pick < 85) c.opcode = ptt_pkg::OP_COMPUTE;
        else if (pick < 93) c.opcode = ptt_pkg::OP_PAN_PLUS;
        else                c.opcode = ptt_pkg::OP_PAN_MINUS;
        c.header = ($urandom_range(9) == 0) ? 8'($urandom) : ptt_pkg::SYNC_BYTE;
        c.x = pick_coord(cfg.ctr_col);
        c.y = pick_coord(cfg.ctr_row);
        c.detected = ($urandom_range(4) != 0);
        return c;
    endfunction

    task automatic drain_and_rest();
        do @(negedge i_clk);
        while (queued_cmds.size() != 0 || predicted_snaps.size() != 0);
        // requests with no snapshot may still be in flight
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // driver: new request at the falling edge once the previous one is taken
    always @(negedge i_clk) begin
        if (!cmd_if.valid || cmd_taken) begin
            if (queued_cmds.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                cmd_if.valid         <= 1'b1;
                cmd_if.opcode        <= queued_cmds[0].opcode;
                cmd_if.packet_header <= queued_cmds[0].header;
                cmd_if.x_in          <= queued_cmds[0].x;
                cmd_if.y_in          <= queued_cmds[0].y;
                cmd_if.detected_in   <= queued_cmds[0].detected;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
        snap_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        cmd_taken = (cmd_if.valid === 1'b1) && (cmd_if.ready === 1'b1);
        if (cmd_taken) begin
            taken_cmd = queued_cmds.pop_front();
            if (advance_tracker(taken_cmd, new_snap)) predicted_snaps.push_back(new_snap);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (snap_if.valid === 1'b1 && snap_if.ready === 1'b1) begin
            got_snap.mode     = snap_if.mode_out;
            got_snap.x        = snap_if.x_out;
            got_snap.y        = snap_if.y_out;
            got_snap.pan      = snap_if.pan_out;
            got_snap.tilt     = snap_if.tilt_out;
            got_snap.detected = snap_if.detected_out;
            got_snap.aimed    = snap_if.aimed_out;
            check_snapshot(got_snap);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1)
            || (snap_if.valid === 1'b1 && snap_if.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        cmd_if.valid = 1'b0;
        cmd_if.opcode = ptt_pkg::OP_START;
        cmd_if.packet_header = 8'd0;
        cmd_if.x_in = '0;
        cmd_if.y_in = '0;
        cmd_if.detected_in = 1'b0;
        snap_if.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;

        cfg.ctr_col = ptt_pkg::CTR_COL_RST;
        cfg.ctr_row = ptt_pkg::CTR_ROW_RST;
        cfg.gain_pan = ptt_pkg::GAIN_RST;
        cfg.gain_tilt = ptt_pkg::GAIN_RST;
        cfg.min_x = ptt_pkg::MIN_X_RST;
        cfg.max_x = ptt_pkg::MAX_X_RST;
        cfg.aim_tol = ptt_pkg::AIM_TOL_RST;
        trk_mode = TRK_IDLE;
        tgt_x = ptt_pkg::CTR_COL_RST;
        tgt_y = ptt_pkg::CTR_ROW_RST;
        pan_ang = AW'(PAN_HOME);
        tilt_ang = AW'(TILT_HOME);
        seen = 1'b0;
        aimed = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // commands that give no snapshot while idle, then start and tick
        push_req(ptt_pkg::OP_TICK, 8'h00, 0, 0, 1'b0);
        push_req(ptt_pkg::OP_STOP, 8'hFF, 1023, 1023, 1'b1);
        push_req(ptt_pkg::OP_CLEAR, 8'h00, 0, 0, 1'b0);
        push_req(ptt_pkg::OP_COMPUTE, 8'h00, 0, 0, 1'b0);
        push_req(ptt_pkg::OP_PAN_MINUS, 8'h00, 0, 0, 1'b0);
        push_req(ptt_pkg::OP_START, 8'h00, 0, 0, 1'b0);
        push_req(ptt_pkg::OP_START, 8'h00, 0, 0, 1'b0);
        push_req(ptt_pkg::OP_TICK, 8'h00, 0, 0, 1'b0);
        // bad sync byte is dropped
        push_req(ptt_pkg::OP_PACKET, 8'hAA, 500, 500, 1'b1);
        // error equal to the tolerance is not aimed
        push_req(ptt_pkg::OP_PACKET, ptt_pkg::SYNC_BYTE, 190, 120, 1'b1);
        push_req(ptt_pkg::OP_PACKET, ptt_pkg::SYNC_BYTE, 189, 149, 1'b1);
        push_req(ptt_pkg::OP_CLEAR, 8'h00, 0, 0, 1'b0);
        push_req(ptt_pkg::OP_PACKET, ptt_pkg::SYNC_BYTE, 1023, 0, 1'b1);
        push_req(ptt_pkg::OP_COMPUTE, 8'h00, 0, 0, 1'b0);
        push_req(ptt_pkg::OP_TICK, 8'h00, 0, 0, 1'b0);
        push_req(ptt_pkg::OP_PACKET, ptt_pkg::SYNC_BYTE, 0, 1023, 1'b0);
        // aimed packet while lost keeps the mode
        push_req(ptt_pkg::OP_PACKET, ptt_pkg::SYNC_BYTE, 160, 120, 1'b1);
        push_req(ptt_pkg::OP_COMPUTE, 8'h00, 0, 0, 1'b0);
        push_req(ptt_pkg::OP_PACKET, ptt_pkg::SYNC_BYTE, 0, 1023, 1'b1);
        push_req(ptt_pkg::OP_COMPUTE, 8'h00, 0, 0, 1'b0);
        push_req(ptt_pkg::OP_PAN_PLUS, 8'h00, 0, 0, 1'b0);
        // error on the deadzone edge still moves, inside it does not
        push_req(ptt_pkg::OP_PACKET, ptt_pkg::SYNC_BYTE, 155, 125, 1'b1);
        push_req(ptt_pkg::OP_COMPUTE, 8'h00, 0, 0, 1'b0);
        push_req(ptt_pkg::OP_PACKET, ptt_pkg::SYNC_BYTE, 156, 124, 1'b1);
        push_req(ptt_pkg::OP_COMPUTE, 8'h00, 0, 0, 1'b0);
        push_req(ptt_pkg::OP_TICK, 8'h00, 0, 0, 1'b0);
        push_req(ptt_pkg::OP_CLEAR, 8'h00, 0, 0, 1'b0);
        push_req(ptt_pkg::OP_STOP, 8'h00, 0, 0, 1'b0);
        drain_and_rest();

        for (int k = 0; k < PHASES; k++) begin
            load_phase(k);
            steady = (k == 4);
            @(posedge i_clk);
            push_req(ptt_pkg::OP_START, ptt_pkg::SYNC_BYTE, 0, 0, 1'b0);
            repeat (PHASE_REQS) queued_cmds.push_back(random_req());
            drain_and_rest();
        end

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
